/* src/idsu_pkg.sv */
// Shared types, constants and saturation helper of the isotropic damage stress update.
package idsu_pkg;

  localparam int unsigned DW       = 48;
  localparam int unsigned CW       = 47;
  localparam int unsigned MUL_IN_W = 49;

  // Register counts of the pipelined units.
  localparam int unsigned MUL_STAGES  = 3;
  localparam int unsigned ROOT_STAGES = 48;
  localparam int unsigned QDIV_STAGES = 48;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_8000_0000_0000;
  localparam logic signed [DW-1:0] SAT_HI48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DW-1:0] SAT_LO48 = 48'sh8000_0000_0000;
  localparam logic [DW-1:0] QUOT_MAX = 48'h7FFF_FFFF_FFFF;

  // Hardening law slopes.
  localparam logic signed [63:0] HARD_RISE = 64'sd10;
  localparam logic signed [63:0] HARD_TAIL = 64'sd5;
  localparam logic [3:0] RISE_DIVISOR = 4'd10;

  typedef enum logic [1:0] {
    CFG_LAME_LAMBDA      = 2'd0,
    CFG_SHEAR_MODULUS    = 2'd1,
    CFG_DAMAGE_THRESHOLD = 2'd2,
    CFG_HARDENING_START  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DW-1:0] strain_xx;
    logic signed [DW-1:0] strain_yy;
    logic signed [DW-1:0] strain_zz;
    logic signed [DW-1:0] strain_xy;
    logic signed [DW-1:0] strain_yz;
    logic signed [DW-1:0] strain_xz;
    logic signed [DW-1:0] radius_in;
    logic signed [DW-1:0] damage_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] stress_xx;
    logic signed [DW-1:0] stress_yy;
    logic signed [DW-1:0] stress_zz;
    logic signed [DW-1:0] stress_xy;
    logic signed [DW-1:0] stress_yz;
    logic signed [DW-1:0] stress_xz;
    logic signed [DW-1:0] radius_out;
    logic signed [DW-1:0] damage_out;
    logic                 nonlinear;
  } out_item_t;

  function automatic logic signed [DW-1:0] sat48(input logic signed [63:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_HI48;
    end else if (v < SAT_MIN) begin
      r = SAT_LO48;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

/* src/idsu_delay.sv */
// Fixed-length register delay line for payload carried alongside the arithmetic units.
module idsu_delay #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    line_q[0] <= data_i;
    for (int unsigned k = 1; k < DEPTH; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  assign data_o = line_q[DEPTH-1];

endmodule

/* src/idsu_mulq.sv */
// Pipelined fixed-point multiplier with rounding half away from zero and 48-bit saturation.
module idsu_mulq #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic signed [idsu_pkg::MUL_IN_W-1:0]  a_i,
  input  logic signed [idsu_pkg::MUL_IN_W-1:0]  b_i,
  output logic signed [idsu_pkg::DW-1:0]        p_o
);

  localparam int unsigned MW = idsu_pkg::MUL_IN_W;
  localparam int unsigned LW = 25;
  localparam int unsigned HW = MW - LW;
  localparam int unsigned PW = 2 * MW + 1;
  localparam int unsigned DW = idsu_pkg::DW;

  logic [MW-1:0] a_mag, b_mag;
  logic [2*LW-1:0] pll_d, pll_q;
  logic [LW+HW-1:0] plh_d, plh_q, phl_d, phl_q;
  logic [2*HW-1:0] phh_d, phh_q;
  logic neg1_q, neg2_q;
  logic [PW-1:0] sum_d, sum_q, shifted;
  logic [DW-1:0] mag48;
  logic signed [DW-1:0] p_d, p_q;

  // The magnitude of the most negative input is still correct as an unsigned value.
  assign a_mag = a_i[MW-1] ? MW'(-a_i) : MW'(a_i);
  assign b_mag = b_i[MW-1] ? MW'(-b_i) : MW'(b_i);

  assign pll_d = a_mag[LW-1:0] * b_mag[LW-1:0];
  assign plh_d = a_mag[LW-1:0] * b_mag[MW-1:LW];
  assign phl_d = a_mag[MW-1:LW] * b_mag[LW-1:0];
  assign phh_d = a_mag[MW-1:LW] * b_mag[MW-1:LW];

  assign sum_d = PW'(pll_q) + (PW'(plh_q) << LW) + (PW'(phl_q) << LW)
               + (PW'(phh_q) << (2 * LW)) + (PW'(1) << (FRAC_BITS - 1));

  always_comb begin
    shifted = sum_q >> FRAC_BITS;
    mag48   = shifted[DW-1:0];
    if (|shifted[PW-1:DW-1]) begin
      p_d = neg2_q ? idsu_pkg::SAT_LO48 : idsu_pkg::SAT_HI48;
    end else begin
      p_d = neg2_q ? -$signed(mag48) : $signed(mag48);
    end
  end

  always_ff @(posedge clk_i) begin
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    phh_q  <= phh_d;
    neg1_q <= a_i[MW-1] ^ b_i[MW-1];
    sum_q  <= sum_d;
    neg2_q <= neg1_q;
    p_q    <= p_d;
  end

  assign p_o = p_q;

endmodule

/* src/idsu_root.sv */
// Pipelined square root, one result bit per stage, of p scaled up by the fraction width.
module idsu_root #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                         clk_i,
  input  logic [idsu_pkg::DW-1:0]      p_i,
  output logic [idsu_pkg::DW-1:0]      root_o
);

  localparam int unsigned DW = idsu_pkg::DW;
  localparam int unsigned NS = idsu_pkg::ROOT_STAGES;
  localparam int unsigned NW = 2 * NS;
  localparam int unsigned RW = NS + 2;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [NS-1:0] root;
    logic [NW-1:0] n;
  } root_stg_t;

  root_stg_t stg_in [NS];
  root_stg_t stg_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    root_stg_t     nxt;
    logic [RW+1:0] rem_sh, trial;

    if (k == 0) begin : g_first
      assign stg_in[k] = '{rem: '0, root: '0, n: NW'(p_i) << FRAC_BITS};
    end else begin : g_next
      assign stg_in[k] = stg_q[k-1];
    end

    always_comb begin
      rem_sh = {stg_in[k].rem, stg_in[k].n[NW-1 -: 2]};
      trial  = (RW+2)'({stg_in[k].root, 2'b01});
      nxt.n  = stg_in[k].n << 2;
      if (rem_sh >= trial) begin
        nxt.rem  = RW'(rem_sh - trial);
        nxt.root = {stg_in[k].root[NS-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh[RW-1:0];
        nxt.root = {stg_in[k].root[NS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k] <= nxt;
    end
  end

  assign root_o = DW'(stg_q[NS-1].root);

endmodule

/* src/idsu_div10.sv */
// Division by ten through a reciprocal product over two register stages, for the hardening knee.
module idsu_div10 (
  input  logic                    clk_i,
  input  logic [idsu_pkg::DW-1:0] x_i,
  output logic [idsu_pkg::DW-1:0] quot_o
);

  localparam int unsigned DW = idsu_pkg::DW;
  localparam int unsigned SH = DW + 4;
  localparam int unsigned HW = DW / 2;
  localparam int unsigned MW = DW + 1;
  localparam int unsigned PW = DW + MW;

  // The reciprocal of ten is rounded up; with this shift the floor quotient is exact for
  // every 48-bit dividend.
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(idsu_pkg::RISE_DIVISOR) - 64'd1)
                                        / 64'(idsu_pkg::RISE_DIVISOR));

  logic [2*HW-1:0] pll_d, pll_q, phl_d, phl_q;
  logic [MW-1:0]   plh_d, plh_q, phh_d, phh_q;
  logic [PW-1:0]   sum;
  logic [DW-1:0]   quot_q;

  assign pll_d = x_i[HW-1:0] * RECIP[HW-1:0];
  assign plh_d = x_i[HW-1:0] * RECIP[MW-1:HW];
  assign phl_d = x_i[DW-1:HW] * RECIP[HW-1:0];
  assign phh_d = x_i[DW-1:HW] * RECIP[MW-1:HW];

  assign sum = PW'(pll_q) + (PW'(plh_q) << HW) + (PW'(phl_q) << HW)
             + (PW'(phh_q) << (2 * HW));

  always_ff @(posedge clk_i) begin
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    phh_q  <= phh_d;
    quot_q <= DW'(sum[PW-1:SH]);
  end

  assign quot_o = quot_q;

endmodule

/* src/idsu_qdiv.sv */
// Pipelined restoring divider giving the saturated quotient q * ONE / r.
module idsu_qdiv #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                    clk_i,
  input  logic [idsu_pkg::DW-1:0] num_i,
  input  logic [idsu_pkg::DW-1:0] den_i,
  output logic [idsu_pkg::DW-1:0] quot_o
);

  localparam int unsigned DW = idsu_pkg::DW;
  localparam int unsigned QB = idsu_pkg::CW;
  localparam int unsigned NW = 2 * DW;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] lo;
    logic [DW-1:0] den;
    logic [QB-1:0] quot;
    logic          big;
  } qdiv_stg_t;

  logic [NW-1:0] numer;
  qdiv_stg_t prep_d, prep_q;
  qdiv_stg_t stg_in [QB];
  qdiv_stg_t stg_q  [QB];

  // A quotient of 2^47 or more saturates, so only 47 bits need long division.
  always_comb begin
    numer       = NW'(num_i) << FRAC_BITS;
    prep_d.big  = numer >= (NW'(den_i) << QB);
    prep_d.rem  = numer[NW-2:QB];
    prep_d.lo   = numer[QB-1:0];
    prep_d.den  = den_i;
    prep_d.quot = '0;
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    qdiv_stg_t   nxt;
    logic [DW:0] rsh;

    if (k == 0) begin : g_first
      assign stg_in[k] = prep_q;
    end else begin : g_next
      assign stg_in[k] = stg_q[k-1];
    end

    always_comb begin
      nxt     = stg_in[k];
      rsh     = {stg_in[k].rem, stg_in[k].lo[QB-1]};
      nxt.lo  = stg_in[k].lo << 1;
      if (rsh >= (DW+1)'(stg_in[k].den)) begin
        nxt.rem  = DW'(rsh - (DW+1)'(stg_in[k].den));
        nxt.quot = {stg_in[k].quot[QB-2:0], 1'b1};
      end else begin
        nxt.rem  = rsh[DW-1:0];
        nxt.quot = {stg_in[k].quot[QB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k] <= nxt;
    end
  end

  assign quot_o = stg_q[QB-1].big ? idsu_pkg::QUOT_MAX : DW'(stg_q[QB-1].quot);

endmodule

/* src/isotropic_damage_stress_update_core.sv */
// Top level of the pipelined isotropic scalar damage stress update.
//
// One integration point is taken on every cycle in which start is high; busy never rises.
// Each item's result appears on result_o with result_valid_o high for one cycle, in order,
// whatever follows it. Its path runs through three 3-stage multipliers with their add
// stages, the 48-stage square root and the 48-stage divider that forms the new damage.
// Items are independent, so the rate is one per cycle for any input. The receiver cannot
// hold results off and none is needed.
// Configuration registers are written through the cfg channel, which is always ready, and
// must only change while no item is in flight.
module isotropic_damage_stress_update_core #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  idsu_pkg::in_item_t    item_i,
  output logic                  result_valid_o,
  output idsu_pkg::out_item_t   result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [idsu_pkg::CW-1:0] cfg_data_i
);

  localparam int unsigned DW   = idsu_pkg::DW;
  localparam int unsigned CW   = idsu_pkg::CW;
  localparam int unsigned MW   = idsu_pkg::MUL_IN_W;
  localparam int unsigned MULS = idsu_pkg::MUL_STAGES;
  localparam int unsigned E_DLY    = MULS + 1;
  localparam int unsigned HIST_DLY = 2 * (MULS + 1) + idsu_pkg::ROOT_STAGES;
  localparam int unsigned HRD_DLY  = idsu_pkg::QDIV_STAGES;
  localparam int unsigned S_DLY    = MULS + 1 + idsu_pkg::ROOT_STAGES + 1
                                   + idsu_pkg::QDIV_STAGES + 1;
  localparam int unsigned PIPE_DEPTH = 1 + 2 * (MULS + 1) + idsu_pkg::ROOT_STAGES + 1
                                     + idsu_pkg::QDIV_STAGES + 1 + MULS;
  localparam logic signed [DW-1:0] QONE = DW'(64'd1 << FRAC_BITS);

  // Configuration registers.
  logic [CW-1:0] lambda_q, mu_q, thr_q, hs_q;
  logic accept;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= '0;
      mu_q     <= '0;
      thr_q    <= '0;
      hs_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (idsu_pkg::cfg_reg_e'(cfg_index_i))
        idsu_pkg::CFG_LAME_LAMBDA:      lambda_q <= cfg_data_i;
        idsu_pkg::CFG_SHEAR_MODULUS:    mu_q     <= cfg_data_i;
        idsu_pkg::CFG_DAMAGE_THRESHOLD: thr_q    <= cfg_data_i;
        idsu_pkg::CFG_HARDENING_START:  hs_q     <= cfg_data_i;
        default:                        lambda_q <= lambda_q;
      endcase
    end
  end

  // Valid bits travel alongside the data.
  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  assign vld_d = {vld_q[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Input register.
  idsu_pkg::in_item_t in_q;
  always_ff @(posedge clk_i) begin
    in_q <= item_i;
  end

  logic signed [DW-1:0] e_in [6];
  logic signed [DW-1:0] trace;
  assign e_in[0] = in_q.strain_xx;
  assign e_in[1] = in_q.strain_yy;
  assign e_in[2] = in_q.strain_zz;
  assign e_in[3] = in_q.strain_xy;
  assign e_in[4] = in_q.strain_yz;
  assign e_in[5] = in_q.strain_xz;
  assign trace = idsu_pkg::sat48(64'(in_q.strain_xx) + 64'(in_q.strain_yy)
                               + 64'(in_q.strain_zz));

  // Elastic stress: lambda * trace, 2 mu on the normal strains, mu on the shears.
  logic signed [MW-1:0] ma_a [7];
  logic signed [MW-1:0] ma_b [7];
  logic signed [DW-1:0] ma_p [7];

  always_comb begin
    ma_a[0] = {2'b00, lambda_q};
    ma_b[0] = MW'(trace);
    for (int i = 0; i < 3; i++) begin
      ma_a[i+1] = {1'b0, mu_q, 1'b0};
      ma_b[i+1] = MW'(e_in[i]);
    end
    for (int i = 3; i < 6; i++) begin
      ma_a[i+1] = {2'b00, mu_q};
      ma_b[i+1] = MW'(e_in[i]);
    end
  end

  for (genvar i = 0; i < 7; i++) begin : g_mul_a
    idsu_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clk_i (clk_i),
      .a_i   (ma_a[i]),
      .b_i   (ma_b[i]),
      .p_o   (ma_p[i])
    );
  end

  logic [6*DW-1:0] e_vec, e4_vec;
  logic signed [DW-1:0] e4 [6];
  logic signed [DW-1:0] s_d [6];
  logic signed [DW-1:0] s_q [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      e_vec[i*DW +: DW] = e_in[i];
      e4[i]             = e4_vec[i*DW +: DW];
    end
    for (int i = 0; i < 3; i++) begin
      s_d[i] = idsu_pkg::sat48(64'(ma_p[0]) + 64'(ma_p[i+1]));
    end
    for (int i = 3; i < 6; i++) begin
      s_d[i] = ma_p[i+1];
    end
  end

  idsu_delay #(.WIDTH(6*DW), .DEPTH(E_DLY)) u_strain_dly (
    .clk_i  (clk_i),
    .data_i (e_vec),
    .data_o (e4_vec)
  );

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  // Energy: sum of stress times strain.
  logic signed [DW-1:0] mb_p [6];
  for (genvar i = 0; i < 6; i++) begin : g_mul_b
    idsu_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clk_i (clk_i),
      .a_i   (MW'(s_q[i])),
      .b_i   (MW'(e4[i])),
      .p_o   (mb_p[i])
    );
  end

  logic signed [63:0] psum;
  logic signed [DW-1:0] p_q;

  always_comb begin
    psum = '0;
    for (int i = 0; i < 6; i++) begin
      psum = psum + 64'(mb_p[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= idsu_pkg::sat48(psum);
  end

  logic [DW-1:0] root;
  idsu_root #(.FRAC_BITS(FRAC_BITS)) u_root (
    .clk_i  (clk_i),
    .p_i    (p_q[DW-1] ? '0 : p_q),
    .root_o (root)
  );

  // Hardening knees, derived from the configuration alone.
  logic signed [DW-1:0] r0_s, thr_s, q1, r1;
  logic [DW-1:0] knee_span, knee_tenth;

  assign r0_s      = {1'b0, hs_q};
  assign thr_s     = {1'b0, thr_q};
  assign q1        = idsu_pkg::sat48(64'(r0_s) * idsu_pkg::HARD_RISE);
  assign knee_span = q1 - r0_s;
  assign r1        = idsu_pkg::sat48(64'(r0_s) + $signed(64'(knee_tenth)));

  idsu_div10 u_div10 (
    .clk_i  (clk_i),
    .x_i    (knee_span),
    .quot_o (knee_tenth)
  );

  logic [2*DW-1:0] hist_vec;
  logic signed [DW-1:0] hist_rin, hist_dmg;

  idsu_delay #(.WIDTH(2*DW), .DEPTH(HIST_DLY)) u_hist_dly (
    .clk_i  (clk_i),
    .data_i ({in_q.radius_in, in_q.damage_in}),
    .data_o (hist_vec)
  );
  assign hist_rin = hist_vec[2*DW-1:DW];
  assign hist_dmg = hist_vec[DW-1:0];

  // Growth test and hardening law.
  logic signed [DW-1:0] root_s, ra, hq_d, hq_q, hr_q, hrad_q, hdmg_q;
  logic hgrow_d, hgrow_q;

  always_comb begin
    root_s  = root;
    ra      = (hist_rin < thr_s) ? thr_s : hist_rin;
    hgrow_d = root_s > ra;
    if (root_s < r0_s) begin
      hq_d = '0;
    end else if (root_s < r1) begin
      hq_d = idsu_pkg::sat48(64'(r0_s)
                           + idsu_pkg::HARD_RISE * (64'(root_s) - 64'(r0_s)));
    end else begin
      hq_d = idsu_pkg::sat48(64'(q1)
                           + idsu_pkg::HARD_TAIL * (64'(root_s) - 64'(r1)));
    end
  end

  always_ff @(posedge clk_i) begin
    hq_q    <= hq_d;
    hr_q    <= root_s;
    hgrow_q <= hgrow_d;
    hrad_q  <= hgrow_d ? root_s : ra;
    hdmg_q  <= hist_dmg;
  end

  logic [DW-1:0] quot;
  idsu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_qdiv (
    .clk_i  (clk_i),
    .num_i  (hq_q),
    .den_i  (hr_q),
    .quot_o (quot)
  );

  logic [2*DW:0] hrd_vec;
  idsu_delay #(.WIDTH(2*DW+1), .DEPTH(HRD_DLY)) u_hrd_dly (
    .clk_i  (clk_i),
    .data_i ({hgrow_q, hrad_q, hdmg_q}),
    .data_o (hrd_vec)
  );

  // When damage grows the scaling factor 1 - D equals the quotient itself.
  logic grow_h;
  logic signed [DW-1:0] rad_h, dmg_h, quot_s;
  logic signed [DW-1:0] fac_q, rad_f_q, dmg_f_q;
  logic nl_f_q;

  assign grow_h = hrd_vec[2*DW];
  assign rad_h  = hrd_vec[2*DW-1:DW];
  assign dmg_h  = hrd_vec[DW-1:0];
  assign quot_s = quot;

  always_ff @(posedge clk_i) begin
    fac_q   <= grow_h ? quot_s : idsu_pkg::sat48(64'(QONE) - 64'(dmg_h));
    dmg_f_q <= grow_h ? idsu_pkg::sat48(64'(QONE) - 64'(quot_s)) : dmg_h;
    rad_f_q <= rad_h;
    nl_f_q  <= grow_h;
  end

  logic [6*DW-1:0] s_vec, s_dly_vec;
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      s_vec[i*DW +: DW] = s_q[i];
    end
  end

  idsu_delay #(.WIDTH(6*DW), .DEPTH(S_DLY)) u_stress_dly (
    .clk_i  (clk_i),
    .data_i (s_vec),
    .data_o (s_dly_vec)
  );

  // Damaged stress.
  logic signed [DW-1:0] mc_p [6];
  for (genvar i = 0; i < 6; i++) begin : g_mul_c
    idsu_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clk_i (clk_i),
      .a_i   (MW'($signed(s_dly_vec[i*DW +: DW]))),
      .b_i   (MW'(fac_q)),
      .p_o   (mc_p[i])
    );
  end

  logic [2*DW:0] meta_vec;
  idsu_delay #(.WIDTH(2*DW+1), .DEPTH(MULS)) u_meta_dly (
    .clk_i  (clk_i),
    .data_i ({rad_f_q, dmg_f_q, nl_f_q}),
    .data_o (meta_vec)
  );

  assign result_valid_o       = vld_q[PIPE_DEPTH-1];
  assign result_o.stress_xx   = mc_p[0];
  assign result_o.stress_yy   = mc_p[1];
  assign result_o.stress_zz   = mc_p[2];
  assign result_o.stress_xy   = mc_p[3];
  assign result_o.stress_yz   = mc_p[4];
  assign result_o.stress_xz   = mc_p[5];
  assign result_o.radius_out  = meta_vec[2*DW:DW+1];
  assign result_o.damage_out  = meta_vec[DW:1];
  assign result_o.nonlinear   = meta_vec[0];

  // Every item taken comes out after the fixed pipeline latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_DEPTH result_valid_o)
    else $error("item did not emerge after the pipeline latency");

  // The radius is never below the non-negative threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !result_o.radius_out[DW-1])
    else $error("negative damage radius");

  // A growing point has a positive radius and damage no larger than one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.nonlinear) |->
      (result_o.radius_out > 0) && (result_o.damage_out <= QONE))
    else $error("growth step with inconsistent radius or damage");

endmodule
